### hdl/tlpc_pkg.sv
// ---------------------------------------------------------------------------
// tlpc_pkg
// Shared codes, widths and bundles of the traffic light phase controller.
// ---------------------------------------------------------------------------
package tlpc_pkg;

  localparam int TIME_W  = 32;
  localparam int DUR_W   = 8;
  localparam int ROAD_W  = 2;
  localparam int LIGHT_W = 3;
  localparam int VEH_W   = 3;
  localparam int BTN_W   = 2;
  localparam int CFG_IDX_W = 3;

  // road codes
  localparam logic [ROAD_W-1:0] ROAD_EW  = 2'd0;
  localparam logic [ROAD_W-1:0] ROAD_MR  = 2'd1;
  localparam logic [ROAD_W-1:0] ROAD_OBH = 2'd2;
  localparam logic [ROAD_W-1:0] ROAD_PED = 2'd3;

  // light codes
  localparam logic [LIGHT_W-1:0] LT_VGREEN  = 3'd0;
  localparam logic [LIGHT_W-1:0] LT_VYELLOW = 3'd1;
  localparam logic [LIGHT_W-1:0] LT_ALLRED  = 3'd2;
  localparam logic [LIGHT_W-1:0] LT_WGREEN  = 3'd3;
  localparam logic [LIGHT_W-1:0] LT_WYELLOW = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_GREEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEH_YELLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_YELLOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE  = 3'd5;

  // register reset values
  localparam logic [DUR_W-1:0] RST_MAIN_GREEN  = 8'd20;
  localparam logic [DUR_W-1:0] RST_SIDE_GREEN  = 8'd10;
  localparam logic [DUR_W-1:0] RST_VEH_YELLOW  = 8'd4;
  localparam logic [DUR_W-1:0] RST_WALK_GREEN  = 8'd10;
  localparam logic [DUR_W-1:0] RST_WALK_YELLOW = 8'd6;
  localparam logic [DUR_W-1:0] RST_CLEARANCE   = 8'd2;

  typedef struct packed {
    logic [DUR_W-1:0] main_green;
    logic [DUR_W-1:0] side_green;
    logic [DUR_W-1:0] veh_yellow;
    logic [DUR_W-1:0] walk_green;
    logic [DUR_W-1:0] walk_yellow;
    logic [DUR_W-1:0] clearance;
  } tlpc_cfg_t;

  typedef struct packed {
    logic [ROAD_W-1:0]  road;
    logic [LIGHT_W-1:0] light;
    logic [TIME_W-1:0]  start;
    logic               latch;
  } tlpc_state_t;

  localparam tlpc_state_t STATE_RST = '{road: ROAD_EW, light: LT_VGREEN,
                                        start: '0, latch: 1'b0};

endpackage

### hdl/tlpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// tlpc_cfg_regs
// Duration register file, written one register at a time.
// ---------------------------------------------------------------------------
module tlpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tlpc_pkg::DUR_W-1:0]     wr_data,
  output tlpc_pkg::tlpc_cfg_t            cfg
);
  import tlpc_pkg::*;

  tlpc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.main_green  <= RST_MAIN_GREEN;
      cfg_r.side_green  <= RST_SIDE_GREEN;
      cfg_r.veh_yellow  <= RST_VEH_YELLOW;
      cfg_r.walk_green  <= RST_WALK_GREEN;
      cfg_r.walk_yellow <= RST_WALK_YELLOW;
      cfg_r.clearance   <= RST_CLEARANCE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAIN_GREEN:  cfg_r.main_green  <= wr_data;
        REG_SIDE_GREEN:  cfg_r.side_green  <= wr_data;
        REG_VEH_YELLOW:  cfg_r.veh_yellow  <= wr_data;
        REG_WALK_GREEN:  cfg_r.walk_green  <= wr_data;
        REG_WALK_YELLOW: cfg_r.walk_yellow <= wr_data;
        REG_CLEARANCE:   cfg_r.clearance   <= wr_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/tlpc_step.sv
// ---------------------------------------------------------------------------
// tlpc_step
// Next-state logic for one timestamp sample: timer compare and phase update.
// ---------------------------------------------------------------------------
module tlpc_step (
  input  tlpc_pkg::tlpc_cfg_t          cfg,
  input  tlpc_pkg::tlpc_state_t        cur,
  input  logic [tlpc_pkg::TIME_W-1:0]  now,
  input  logic [tlpc_pkg::VEH_W-1:0]   veh,
  input  logic [tlpc_pkg::BTN_W-1:0]   btn,
  output tlpc_pkg::tlpc_state_t        nxt
);
  import tlpc_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic [ROAD_W-1:0] next_road;
  logic              present;
  logic [DUR_W-1:0]  green_dur;
  logic              want_walk;
  logic              latch_set;

  function automatic logic expired(input logic [TIME_W-1:0] el,
                                   input logic [DUR_W-1:0] dur);
    expired = (el >= {{(TIME_W-DUR_W){1'b0}}, dur});
  endfunction

  assign elapsed   = now - cur.start;   // wraps mod 2^32
  assign next_road = (cur.road == ROAD_OBH) ? ROAD_EW : cur.road + 2'd1;
  assign green_dur = (cur.road == ROAD_EW) ? cfg.main_green : cfg.side_green;
  assign latch_set = cur.latch | ((btn != '0) && (cur.road != ROAD_PED));
  // OBH looks at the live button, not the latch
  assign want_walk = (cur.road == ROAD_OBH) ? btn[1] : latch_set;

  always_comb begin
    case (cur.road)
      ROAD_EW:  present = veh[2];
      ROAD_MR:  present = veh[1];
      ROAD_OBH: present = veh[0];
      default:  present = 1'b0;
    endcase
  end

  always_comb begin
    nxt       = cur;
    nxt.latch = latch_set;
    if (cur.road == ROAD_PED) begin
      case (cur.light)
        LT_WGREEN: begin
          if (expired(elapsed, cfg.walk_green)) begin
            nxt.light = LT_WYELLOW;
            nxt.start = now;
          end
        end
        LT_WYELLOW: begin
          if (expired(elapsed, cfg.walk_yellow)) begin
            nxt.light = LT_ALLRED;
            nxt.start = now;
          end
        end
        LT_ALLRED: begin
          if (expired(elapsed, cfg.clearance)) begin
            nxt.latch = 1'b0;
            nxt.start = now;
            if (veh == '0) begin
              nxt.light = LT_WGREEN;
            end else begin
              nxt.road  = ROAD_EW;
              nxt.light = LT_VGREEN;
            end
          end
        end
        default: ;
      endcase
    end else if (!present) begin
      // empty road: skip ahead, light kept
      nxt.road  = next_road;
      nxt.start = now;
    end else begin
      case (cur.light)
        LT_VGREEN: begin
          if (expired(elapsed, green_dur)) begin
            nxt.light = LT_VYELLOW;
            nxt.start = now;
          end
        end
        LT_VYELLOW: begin
          if (expired(elapsed, cfg.veh_yellow)) begin
            nxt.light = LT_ALLRED;
            nxt.start = now;
          end
        end
        LT_ALLRED: begin
          if (expired(elapsed, cfg.clearance)) begin
            nxt.start = now;
            if (want_walk) begin
              nxt.road  = ROAD_PED;
              nxt.light = LT_WGREEN;
            end else begin
              nxt.road  = next_road;
              nxt.light = LT_VGREEN;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/traffic_light_phase_controller.sv
// ---------------------------------------------------------------------------
// traffic_light_phase_controller
// Three-road traffic light sequencer with latched pedestrian service.
// ---------------------------------------------------------------------------
// Each accepted item is one timestamp sample with vehicle sensors and walk
// buttons; each yields exactly one result item giving road, light and the
// walk latch after that sample. Throughput is one item per clock unless
// out_stall holds the result register: the input register feeds a
// combinational step (one 32-bit subtract and compare against the selected
// duration) whose result is written to the phase state and to the output
// register in the same cycle, so the next sample sees it right away. Items
// pass the input register, then the result register. in_stall rises only
// when the input register is full and the output register is held by
// out_stall. Durations are written through the cfg_ port (always ready);
// write them only while no item is in flight.
// ---------------------------------------------------------------------------
module traffic_light_phase_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tlpc_pkg::TIME_W-1:0]     in_now,
  input  logic [tlpc_pkg::VEH_W-1:0]      in_vehicle_sensors,
  input  logic [tlpc_pkg::BTN_W-1:0]      in_walk_buttons,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tlpc_pkg::ROAD_W-1:0]     out_road_phase,
  output logic [tlpc_pkg::LIGHT_W-1:0]    out_light_phase,
  output logic                            out_walk_pending,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlpc_pkg::DUR_W-1:0]      cfg_data
);
  import tlpc_pkg::*;

  tlpc_cfg_t   cfg;
  tlpc_state_t state_r;
  tlpc_state_t state_nxt;

  // input register
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [VEH_W-1:0]  s1_veh_r;
  logic [BTN_W-1:0]  s1_btn_r;

  // result register
  logic               out_valid_r;
  logic [ROAD_W-1:0]  out_road_r;
  logic [LIGHT_W-1:0] out_light_r;
  logic               out_pend_r;

  logic out_free;   // result register can take a new item this cycle
  logic s1_fire;    // step executes, state commits
  logic in_take;

  assign cfg_ready = 1'b1;

  tlpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlpc_step u_step (
    .cfg (cfg),
    .cur (state_r),
    .now (s1_now_r),
    .veh (s1_veh_r),
    .btn (s1_btn_r),
    .nxt (state_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register: refills whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= in_now;
      s1_veh_r <= in_vehicle_sensors;
      s1_btn_r <= in_walk_buttons;
    end
  end

  // phase state commits exactly once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_road_r  <= state_nxt.road;
      out_light_r <= state_nxt.light;
      out_pend_r  <= state_nxt.latch;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_road_phase   = out_road_r;
  assign out_light_phase  = out_light_r;
  assign out_walk_pending = out_pend_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // phase state moves only when an item is stepped
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(state_r))
    else $error("phase state changed without an item");

  // pedestrian service never shows a vehicle green or yellow
  a_ped_light: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_road_r == ROAD_PED) |->
      (out_light_r != LT_VGREEN && out_light_r != LT_VYELLOW))
    else $error("pedestrian phase with vehicle light");

  // vehicle roads never show a walk light
  a_veh_light: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_road_r != ROAD_PED) |->
      (out_light_r == LT_VGREEN || out_light_r == LT_VYELLOW ||
       out_light_r == LT_ALLRED))
    else $error("vehicle road with walk light");

  // back-pressure only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the traffic light phase controller.
// ---------------------------------------------------------------------------
// Drives timestamp/sensor/button items into the block with random gaps and
// random result stalls. An in-bench phase predictor tracks road, light, entry
// time and walk latch, and every result item is checked field by field in
// order. A short scripted walk through all phases comes first, then random
// traffic under several duration settings, zero and full scale among them.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpc_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int ITEMS_PER_SET = 296;
  localparam int SCRIPT_LEN    = 25;
  localparam int TAIL_CYCLES   = 8;
  localparam int RANDOM_SETS   = 4;

  // one result item: what the lights show after a sample
  typedef struct packed {
    logic [ROAD_W-1:0]  road;
    logic [LIGHT_W-1:0] light;
    logic               latch;
  } light_view_t;

  // scripted sample; when typed is set, the result is given by hand
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [VEH_W-1:0]  veh;
    logic [BTN_W-1:0]  btn;
    logic              typed;
    light_view_t       view;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_now = '0;
  logic [VEH_W-1:0]     in_vehicle_sensors = '0;
  logic [BTN_W-1:0]     in_walk_buttons = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROAD_W-1:0]    out_road_phase;
  logic [LIGHT_W-1:0]   out_light_phase;
  logic                 out_walk_pending;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data = '0;

  // predictor copy of the phase state and the durations
  tlpc_state_t  phase_ctl;
  tlpc_cfg_t    durations;
  light_view_t  pending_views[$];

  script_row_t  script_rows [SCRIPT_LEN];
  tlpc_cfg_t    setting;
  logic [TIME_W-1:0] clock_now;
  int           errors = 0;
  int           cycles = 0;
  int           rx_wait = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;

  traffic_light_phase_controller u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_now             (in_now),
    .in_vehicle_sensors (in_vehicle_sensors),
    .in_walk_buttons    (in_walk_buttons),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_road_phase     (out_road_phase),
    .out_light_phase    (out_light_phase),
    .out_walk_pending   (out_walk_pending),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // hard stop in case the block hangs on either handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[traffic_light_phase_controller] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Phase predictor
  // ---------------------------------------------------------------------
  function automatic void set_phase(input logic [ROAD_W-1:0] road,
                                    input logic [LIGHT_W-1:0] light,
                                    input logic [TIME_W-1:0] t);
    phase_ctl.road  = road;
    phase_ctl.light = light;
    phase_ctl.start = t;
  endfunction

  function automatic light_view_t next_phase(input logic [TIME_W-1:0] t,
                                             input logic [VEH_W-1:0] veh,
                                             input logic [BTN_W-1:0] btn);
    logic [TIME_W-1:0] elapsed;
    logic [ROAD_W-1:0] road;
    logic [ROAD_W-1:0] nxt;
    logic [DUR_W-1:0]  green;
    logic              present;
    logic              want_walk;
    light_view_t       v;
    elapsed = t - phase_ctl.start;   // wraps mod 2^32
    road = phase_ctl.road;
    // any button latches a walk request, except during walk service itself
    if (btn != '0 && road != ROAD_PED)
      phase_ctl.latch = 1'b1;
    if (road == ROAD_PED) begin
      if (phase_ctl.light == LT_WGREEN) begin
        if (elapsed >= durations.walk_green)
          set_phase(ROAD_PED, LT_WYELLOW, t);
      end else if (phase_ctl.light == LT_WYELLOW) begin
        if (elapsed >= durations.walk_yellow)
          set_phase(ROAD_PED, LT_ALLRED, t);
      end else if (phase_ctl.light == LT_ALLRED) begin
        if (elapsed >= durations.clearance) begin
          phase_ctl.latch = 1'b0;
          // nobody waiting in a car: walk again
          if (veh == '0)
            set_phase(ROAD_PED, LT_WGREEN, t);
          else
            set_phase(ROAD_EW, LT_VGREEN, t);
        end
      end
    end else begin
      nxt = (road == ROAD_OBH) ? ROAD_EW : road + 2'd1;
      present = veh[VEH_W - 1 - int'(road)];
      green = (road == ROAD_EW) ? durations.main_green : durations.side_green;
      // OBH looks at the live button bit, the others at the latch
      want_walk = (road == ROAD_OBH) ? btn[1] : phase_ctl.latch;
      if (!present) begin
        // empty road: skip ahead, light kept as is
        set_phase(nxt, phase_ctl.light, t);
      end else if (phase_ctl.light == LT_VGREEN) begin
        if (elapsed >= green)
          set_phase(road, LT_VYELLOW, t);
      end else if (phase_ctl.light == LT_VYELLOW) begin
        if (elapsed >= durations.veh_yellow)
          set_phase(road, LT_ALLRED, t);
      end else if (phase_ctl.light == LT_ALLRED) begin
        if (elapsed >= durations.clearance) begin
          if (want_walk)
            set_phase(ROAD_PED, LT_WGREEN, t);
          else
            set_phase(nxt, LT_VGREEN, t);
        end
      end
    end
    v.road  = phase_ctl.road;
    v.light = phase_ctl.light;
    v.latch = phase_ctl.latch;
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Sample side: gap, present, hold until accepted, then predict
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VEH_W-1:0] veh,
                             input logic [BTN_W-1:0] btn, input logic typed,
                             input light_view_t view);
    int gap;
    light_view_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_now             <= t;
    in_vehicle_sensors <= veh;
    in_walk_buttons    <= btn;
    do @(posedge clk); while (in_stall);
    predicted = next_phase(t, veh, btn);
    pending_views.push_back(typed ? view : predicted);
  endtask

  // park the sample side until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAIN_GREEN:  durations.main_green  = val;
      REG_SIDE_GREEN:  durations.side_green  = val;
      REG_VEH_YELLOW:  durations.veh_yellow  = val;
      REG_WALK_GREEN:  durations.walk_green  = val;
      REG_WALK_YELLOW: durations.walk_yellow = val;
      REG_CLEARANCE:   durations.clearance   = val;
      default: ;
    endcase
  endtask

  // only written with the pipe empty
  task automatic apply_setting(input tlpc_cfg_t s);
    drain_results();
    write_reg(REG_MAIN_GREEN, s.main_green);
    write_reg(REG_SIDE_GREEN, s.side_green);
    write_reg(REG_VEH_YELLOW, s.veh_yellow);
    write_reg(REG_WALK_GREEN, s.walk_green);
    write_reg(REG_WALK_YELLOW, s.walk_yellow);
    write_reg(REG_CLEARANCE, s.clearance);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. The clock mostly creeps forward at a pace set by the
  // longest duration so every light gets to time out; now and then it
  // jumps, steps back, or lands just under the wrap.
  task automatic run_traffic(input int count);
    int roll;
    int stride;
    logic [VEH_W-1:0] veh;
    logic [BTN_W-1:0] btn;
    stride = durations.main_green;
    if (durations.side_green > stride) stride = durations.side_green;
    if (durations.veh_yellow > stride) stride = durations.veh_yellow;
    if (durations.walk_green > stride) stride = durations.walk_green;
    if (durations.walk_yellow > stride) stride = durations.walk_yellow;
    if (durations.clearance > stride) stride = durations.clearance;
    stride = stride / 3 + 2;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)
        clock_now = $urandom;
      else if (roll < 7)
        clock_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else if (roll < 9)
        clock_now = clock_now - $urandom_range(1, 300);
      else
        clock_now = clock_now + $urandom_range(0, stride);
      veh = ($urandom_range(0, 9) < 7) ? 3'b111 : 3'($urandom_range(0, 7));
      btn = ($urandom_range(0, 9) < 8) ? 2'b00 : 2'($urandom_range(0, 3));
      send_sample(clock_now, veh, btn, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall per item, in-order field check
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    light_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: unexpected item road %0d light %0d walk %0d", $time,
                 out_road_phase, out_light_phase, out_walk_pending);
      end else begin
        want = pending_views.pop_front();
        if (out_road_phase !== want.road) begin
          errors++;
          $display("%0t: road_phase expected %0d got %0d", $time, want.road, out_road_phase);
        end
        if (out_light_phase !== want.light) begin
          errors++;
          $display("%0t: light_phase expected %0d got %0d", $time, want.light,
                   out_light_phase);
        end
        if (out_walk_pending !== want.latch) begin
          errors++;
          $display("%0t: walk_pending expected %0d got %0d", $time, want.latch,
                   out_walk_pending);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    phase_ctl = STATE_RST;
    durations = '{RST_MAIN_GREEN, RST_SIDE_GREEN, RST_VEH_YELLOW,
                  RST_WALK_GREEN, RST_WALK_YELLOW, RST_CLEARANCE};
    // Scripted walk under reset durations (20/10/4/10/6/2).
    script_rows = '{
      // EW green holds, then yellow; a button on yellow sets the latch
      '{32'd0,  3'b111, 2'b00, 1'b1, '{ROAD_EW,  LT_VGREEN,  1'b0}},
      '{32'd20, 3'b111, 2'b00, 1'b1, '{ROAD_EW,  LT_VYELLOW, 1'b0}},
      '{32'd24, 3'b111, 2'b01, 1'b1, '{ROAD_EW,  LT_ALLRED,  1'b1}},
      // latch sends EW clearance into walk service
      '{32'd26, 3'b111, 2'b00, 1'b1, '{ROAD_PED, LT_WGREEN,  1'b1}},
      // buttons during walk service are ignored
      '{32'd36, 3'b111, 2'b11, 1'b1, '{ROAD_PED, LT_WYELLOW, 1'b1}},
      '{32'd42, 3'b111, 2'b00, 1'b1, '{ROAD_PED, LT_ALLRED,  1'b1}},
      // no cars at end of walk: walk restarts, latch cleared
      '{32'd44, 3'b000, 2'b00, 1'b1, '{ROAD_PED, LT_WGREEN,  1'b0}},
      '{32'd54, 3'b000, 2'b00, 1'b0, '0},
      '{32'd60, 3'b000, 2'b00, 1'b0, '0},
      '{32'd62, 3'b111, 2'b00, 1'b1, '{ROAD_EW,  LT_VGREEN,  1'b0}},
      // EW empty: skip to MR with green kept
      '{32'd62, 3'b011, 2'b00, 1'b1, '{ROAD_MR,  LT_VGREEN,  1'b0}},
      '{32'd72, 3'b010, 2'b00, 1'b0, '0},
      '{32'd76, 3'b010, 2'b00, 1'b0, '0},
      '{32'd78, 3'b010, 2'b00, 1'b0, '0},
      '{32'd88, 3'b001, 2'b00, 1'b0, '0},
      '{32'd92, 3'b001, 2'b00, 1'b0, '0},
      // OBH clearance with button bit1 live: straight to walk
      '{32'd94, 3'b001, 2'b10, 1'b1, '{ROAD_PED, LT_WGREEN,  1'b1}},
      // timestamp extremes and wrap of the elapsed time
      '{32'hFFFF_FFFF, 3'b111, 2'b00, 1'b0, '0},
      '{32'd5,  3'b111, 2'b00, 1'b0, '0},
      '{32'd7,  3'b110, 2'b00, 1'b0, '0},
      // empty roads around the ring, button on an empty OBH
      '{32'd7,  3'b011, 2'b00, 1'b0, '0},
      '{32'd7,  3'b001, 2'b00, 1'b0, '0},
      '{32'd7,  3'b110, 2'b01, 1'b0, '0},
      '{32'h8000_0000, 3'b100, 2'b00, 1'b0, '0},
      '{32'h8000_0004, 3'b100, 2'b00, 1'b0, '0}
    };
    clock_now = 32'h8000_0004;

    // synchronous reset, once
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < SCRIPT_LEN; k++)
      send_sample(script_rows[k].now, script_rows[k].veh, script_rows[k].btn,
                  script_rows[k].typed, script_rows[k].view);

    // reset durations, with one full stop on the sample side midway
    run_traffic(ITEMS_PER_SET / 2);
    drain_results();
    run_traffic(ITEMS_PER_SET / 2);

    // every duration zero: each light lasts one sample
    apply_setting('0);
    run_traffic(ITEMS_PER_SET);

    // every duration at full scale
    apply_setting('1);
    run_traffic(ITEMS_PER_SET);

    // mixed settings, mostly short durations so phases turn over often
    for (int s = 0; s < RANDOM_SETS; s++) begin
      setting.main_green  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      setting.side_green  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      setting.veh_yellow  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      setting.walk_green  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      setting.walk_yellow = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      setting.clearance   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      apply_setting(setting);
      run_traffic(ITEMS_PER_SET);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[traffic_light_phase_controller] OK");
    else
      $display("[traffic_light_phase_controller] ERROR");
    $finish;
  end

endmodule

### traffic_light_phase_controller.f
hdl/tlpc_pkg.sv
hdl/tlpc_cfg_regs.sv
hdl/tlpc_step.sv
hdl/traffic_light_phase_controller.sv
bench/tb.sv
